>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks used by the asserting file, the core top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/pwlci_pkg.sv
// ----------------------------------------------------------------------------
// pwlci_pkg
// Point table, job word and queue status types for the index interpolator.
// ----------------------------------------------------------------------------
package pwlci_pkg;

    localparam int NUM_POINTS = 14;
    localparam int TABLE_DEPTH = 16;
    localparam int NPTS = (NUM_POINTS < 2) ? 2 :
                          ((NUM_POINTS > TABLE_DEPTH) ? TABLE_DEPTH : NUM_POINTS);
    localparam int IDX_W = $clog2(TABLE_DEPTH);

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NPTS - 1);
    localparam logic [IDX_W-1:0] SEG_LAST = IDX_W'(NPTS - 2);

    localparam int Q_DEPTH = 2;
    localparam int Q_AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_LW = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] FLAG_MIX  = 2'd0;
    localparam logic [1:0] FLAG_LOW  = 2'd1;
    localparam logic [1:0] FLAG_HIGH = 2'd2;

    localparam logic [15:0] RE_NONE = 16'd8192;
    localparam logic [15:0] IM_NONE = 16'd0;

    typedef struct packed {
        logic [15:0] wl;
        logic [15:0] re;
        logic [15:0] im;
    } t_point;

    typedef enum logic [1:0] {
        KIND_MIX  = 2'd0,
        KIND_LOW  = 2'd1,
        KIND_HIGH = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    // one classified word handed from the search to the interpolator
    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] seg;
        logic [15:0]      d1;
        logic [15:0]      d2;
    } t_job;

    typedef struct packed {
        logic            full;
        logic            empty;
        logic [Q_LW-1:0] level;
    } t_q_stat;

    function automatic t_point pwlci_point(input logic [IDX_W-1:0] idx);
        t_point p;
        case (idx)
            4'd0:    p = '{wl: 16'd2032,  re: 16'd3817,  im: 16'd8929};
            4'd1:    p = '{wl: 16'd2258,  re: 16'd4088,  im: 16'd10895};
            4'd2:    p = '{wl: 16'd2540,  re: 16'd4538,  im: 16'd13599};
            4'd3:    p = '{wl: 16'd2902,  re: 16'd5489,  im: 16'd17039};
            4'd4:    p = '{wl: 16'd3385,  re: 16'd7873,  im: 16'd21709};
            4'd5:    p = '{wl: 16'd4063,  re: 16'd13599, im: 16'd27689};
            4'd6:    p = '{wl: 16'd4514,  re: 16'd18924, im: 16'd30392};
            4'd7:    p = '{wl: 16'd5079,  re: 16'd27525, im: 16'd32113};
            4'd8:    p = '{wl: 16'd5805,  re: 16'd37601, im: 16'd27689};
            4'd9:    p = '{wl: 16'd6772,  re: 16'd44483, im: 16'd17940};
            4'd10:   p = '{wl: 16'd8126,  re: 16'd43008, im: 16'd8126};
            4'd11:   p = '{wl: 16'd10156, re: 16'd38584, im: 16'd1778};
            4'd12:   p = '{wl: 16'd13418, re: 16'd31949, im: 16'd183};
            default: p = '{wl: 16'd15750, re: 16'd29983, im: 16'd90};
        endcase
        return p;
    endfunction

endpackage

>>> design/pwlci_front.sv
// ----------------------------------------------------------------------------
// pwlci_front
// Accepts a wavelength, clamps or walks the segments one per cycle, and
// pushes the classified job into the queue.
// ----------------------------------------------------------------------------
module pwlci_front
    import pwlci_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_wavelength,
    input  t_q_stat     i_q_stat,
    output logic        o_push,
    output t_job        o_job
);

    typedef enum logic [2:0] {
        F_IDLE   = 3'b001,
        F_SEARCH = 3'b010,
        F_PUSH   = 3'b100
    } t_fstate;

    t_fstate          r_state, n_state;
    logic [15:0]      r_lam, n_lam;
    logic [IDX_W-1:0] r_seg, n_seg;
    t_job             r_job, n_job;

    t_point p_first, p_last, p_lo, p_hi;

    always_comb begin
        p_first = pwlci_point('0);
        p_last  = pwlci_point(IDX_LAST);
        p_lo    = pwlci_point(r_seg);
        p_hi    = pwlci_point(r_seg + 1'b1);
    end

    always_comb begin
        n_state = r_state;
        n_lam   = r_lam;
        n_seg   = r_seg;
        n_job   = r_job;
        case (r_state)
            F_IDLE: begin
                if (i_valid) begin
                    n_lam  = i_wavelength;
                    n_job.d1 = '0;
                    n_job.d2 = '0;
                    if (i_wavelength < p_first.wl) begin
                        n_job.kind = KIND_LOW;
                        n_job.seg  = '0;
                        n_state    = F_PUSH;
                    end else if (i_wavelength > p_last.wl) begin
                        n_job.kind = KIND_HIGH;
                        n_job.seg  = IDX_LAST;
                        n_state    = F_PUSH;
                    end else begin
                        n_seg   = '0;
                        n_state = F_SEARCH;
                    end
                end
            end
            F_SEARCH: begin
                if (r_lam >= p_lo.wl && r_lam <= p_hi.wl) begin
                    n_job.kind = KIND_MIX;
                    n_job.seg  = r_seg;
                    n_job.d1   = r_lam - p_lo.wl;
                    n_job.d2   = p_hi.wl - r_lam;
                    n_state    = F_PUSH;
                end else if (r_seg == SEG_LAST) begin
                    n_job.kind = KIND_NONE;
                    n_job.seg  = r_seg;
                    n_state    = F_PUSH;
                end else begin
                    n_seg = r_seg + 1'b1;
                end
            end
            F_PUSH: begin
                if (!i_q_stat.full) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_lam <= n_lam;
        r_seg <= n_seg;
        r_job <= n_job;
    end

    assign o_stall = (r_state != F_IDLE);
    assign o_push  = (r_state == F_PUSH) && !i_q_stat.full;
    assign o_job   = r_job;

endmodule

>>> design/pwlci_queue.sv
// ----------------------------------------------------------------------------
// pwlci_queue
// Short job queue between the search front and the interpolating back.
// ----------------------------------------------------------------------------
module pwlci_queue
    import pwlci_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_job    i_job,
    input  logic    i_pop,
    output t_job    o_job,
    output t_q_stat o_stat
);

    localparam logic [Q_AW-1:0] PTR_LAST = Q_AW'(Q_DEPTH - 1);
    localparam logic [Q_LW-1:0] LVL_FULL = Q_LW'(Q_DEPTH);

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_LW-1:0] r_level;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_level <= r_level + 1'b1;
                2'b01:   r_level <= r_level - 1'b1;
                default: r_level <= r_level;
            endcase
        end
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_job        = r_mem[r_rp];
    assign o_stat.full  = (r_level == LVL_FULL);
    assign o_stat.empty = (r_level == '0);
    assign o_stat.level = r_level;

endmodule

>>> design/pwlci_back.sv
// ----------------------------------------------------------------------------
// pwlci_back
// Takes jobs off the queue, forms the weighted sums on one shared multiplier
// and divides both parts by the segment width, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module pwlci_back
    import pwlci_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_stat     i_q_stat,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_index_real,
    output logic [15:0] o_index_imag,
    output logic [1:0]  o_range_flag
);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_MUL  = 4'b0010,
        B_DIV  = 4'b0100,
        B_OUT  = 4'b1000
    } t_bstate;

    t_bstate     r_state, n_state;
    t_job        r_job, n_job;
    logic [1:0]  r_k, n_k;
    logic [3:0]  r_cnt, n_cnt;
    logic [31:0] r_acc, n_acc;
    logic [15:0] r_rem_re, n_rem_re, r_rem_im, n_rem_im;
    logic [15:0] r_lo_re, n_lo_re, r_lo_im, n_lo_im;
    logic [15:0] r_res_re, n_res_re, r_res_im, n_res_im;
    logic [1:0]  r_res_flag, n_res_flag;
    logic        r_o_valid, n_o_valid;
    logic [15:0] r_o_re, n_o_re, r_o_im, n_o_im;
    logic [1:0]  r_o_flag, n_o_flag;

    t_point      p_new, p_a, p_b;
    logic [15:0] op_x, op_y, w;
    logic [31:0] prod, sum;
    logic [16:0] t_re, t_im;
    logic        ge_re, ge_im;

    always_comb begin
        p_new = pwlci_point(i_job.seg);
        p_a   = pwlci_point(r_job.seg);
        p_b   = pwlci_point(r_job.seg + 1'b1);
        // segment width never exceeds the 16-bit wavelength span
        w     = 16'(r_job.d1 + r_job.d2);
    end

    // one product a cycle: a*d2 then b*d1 for each part
    always_comb begin
        case (r_k)
            2'd0:    begin op_x = p_a.re; op_y = r_job.d2; end
            2'd1:    begin op_x = p_b.re; op_y = r_job.d1; end
            2'd2:    begin op_x = p_a.im; op_y = r_job.d2; end
            default: begin op_x = p_b.im; op_y = r_job.d1; end
        endcase
        prod = op_x * op_y;
        // weighted average numerator stays below 2^32
        sum  = 32'(r_acc + prod);
    end

    // restoring division step for both parts
    always_comb begin
        t_re  = {r_rem_re, r_lo_re[15]};
        t_im  = {r_rem_im, r_lo_im[15]};
        ge_re = (t_re >= {1'b0, w});
        ge_im = (t_im >= {1'b0, w});
    end

    assign o_pop = (r_state == B_IDLE) && !i_q_stat.empty;

    always_comb begin
        n_state    = r_state;
        n_job      = r_job;
        n_k        = r_k;
        n_cnt      = r_cnt;
        n_acc      = r_acc;
        n_rem_re   = r_rem_re;
        n_rem_im   = r_rem_im;
        n_lo_re    = r_lo_re;
        n_lo_im    = r_lo_im;
        n_res_re   = r_res_re;
        n_res_im   = r_res_im;
        n_res_flag = r_res_flag;
        n_o_valid  = r_o_valid && i_stall;
        n_o_re     = r_o_re;
        n_o_im     = r_o_im;
        n_o_flag   = r_o_flag;
        case (r_state)
            B_IDLE: begin
                if (!i_q_stat.empty) begin
                    n_job = i_job;
                    n_k   = '0;
                    case (i_job.kind)
                        KIND_MIX: begin
                            n_res_flag = FLAG_MIX;
                            if (i_job.d1 == '0 && i_job.d2 == '0) begin
                                // zero-width segment: first end as is
                                n_res_re = p_new.re;
                                n_res_im = p_new.im;
                                n_state  = B_OUT;
                            end else begin
                                n_state = B_MUL;
                            end
                        end
                        KIND_LOW: begin
                            n_res_re   = p_new.re;
                            n_res_im   = p_new.im;
                            n_res_flag = FLAG_LOW;
                            n_state    = B_OUT;
                        end
                        KIND_HIGH: begin
                            n_res_re   = p_new.re;
                            n_res_im   = p_new.im;
                            n_res_flag = FLAG_HIGH;
                            n_state    = B_OUT;
                        end
                        default: begin
                            n_res_re   = RE_NONE;
                            n_res_im   = IM_NONE;
                            n_res_flag = FLAG_MIX;
                            n_state    = B_OUT;
                        end
                    endcase
                end
            end
            B_MUL: begin
                n_k = r_k + 1'b1;
                case (r_k)
                    2'd0: n_acc = prod;
                    2'd1: begin
                        n_rem_re = sum[31:16];
                        n_lo_re  = sum[15:0];
                        n_acc    = sum;
                    end
                    2'd2: n_acc = prod;
                    default: begin
                        n_rem_im = sum[31:16];
                        n_lo_im  = sum[15:0];
                        n_cnt    = '0;
                        n_state  = B_DIV;
                    end
                endcase
            end
            B_DIV: begin
                n_rem_re = ge_re ? 16'(t_re - {1'b0, w}) : t_re[15:0];
                n_rem_im = ge_im ? 16'(t_im - {1'b0, w}) : t_im[15:0];
                n_lo_re  = {r_lo_re[14:0], ge_re};
                n_lo_im  = {r_lo_im[14:0], ge_im};
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == 4'd15) begin
                    n_res_re   = {r_lo_re[14:0], ge_re};
                    n_res_im   = {r_lo_im[14:0], ge_im};
                    n_res_flag = FLAG_MIX;
                    n_state    = B_OUT;
                end
            end
            B_OUT: begin
                if (!r_o_valid || !i_stall) begin
                    n_o_valid = 1'b1;
                    n_o_re    = r_res_re;
                    n_o_im    = r_res_im;
                    n_o_flag  = r_res_flag;
                    n_state   = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= B_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
        end
        r_job      <= n_job;
        r_k        <= n_k;
        r_cnt      <= n_cnt;
        r_acc      <= n_acc;
        r_rem_re   <= n_rem_re;
        r_rem_im   <= n_rem_im;
        r_lo_re    <= n_lo_re;
        r_lo_im    <= n_lo_im;
        r_res_re   <= n_res_re;
        r_res_im   <= n_res_im;
        r_res_flag <= n_res_flag;
        r_o_re     <= n_o_re;
        r_o_im     <= n_o_im;
        r_o_flag   <= n_o_flag;
    end

    assign o_valid      = r_o_valid;
    assign o_index_real = r_o_re;
    assign o_index_imag = r_o_im;
    assign o_range_flag = r_o_flag;

endmodule

>>> design/piecewise_linear_complex_index_core.sv
// Path: a clamped word goes from the front push state through the queue to
//   the back output state and the output register; an interpolated one also
//   walks the segments and runs the back-end arithmetic. The back end takes one
//   word at a time (1 pop, 4 products on the shared multiplier, 16 divide steps,
//   1 output) and so paces interpolated words. The front walks one segment a cycle.
// Reset: synchronous, active low; clears the control state, the table is fixed.
// ----------------------------------------------------------------------------
// piecewise_linear_complex_index_core
// Piecewise linear interpolation of a complex refractive index over a fixed
// wavelength point table, with clamping outside the table.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module piecewise_linear_complex_index_core
    import pwlci_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // query word
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_wavelength,
    // result word
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_index_real,
    output logic [15:0] o_index_imag,
    output logic [1:0]  o_range_flag
);

    // Front: takes the query, settles the clamp cases at once and otherwise
    // scans the segments from the first, one compare pair a cycle, so the
    // first segment holding the wavelength wins (a hit on a point returns
    // that point exactly). It then holds the job until the queue has room.
    t_job    front_job;
    logic    front_push;
    t_q_stat q_stat;
    t_job    q_job;
    logic    back_pop;

    pwlci_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_wavelength (i_wavelength),
        .i_q_stat     (q_stat),
        .o_push       (front_push),
        .o_job        (front_job)
    );

    // Queue: decouples the search from the divide, so a fresh query can be
    // scanned while an earlier one is still being divided.
    pwlci_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .i_pop   (back_pop),
        .o_job   (q_job),
        .o_stat  (q_stat)
    );

    // Back: numerator a*d2 + b*d1 for each part, then a truncating divide by
    // the segment width. Zero-width segments and clamps skip the arithmetic.
    // The output register lets the next job start while a word waits.
    pwlci_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_stat     (q_stat),
        .i_job        (q_job),
        .o_pop        (back_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_index_real (o_index_real),
        .o_index_imag (o_index_imag),
        .o_range_flag (o_range_flag)
    );

    // ---- checks ----
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "front took a word but did not go busy")
    `ASSERT_IMPL(a_flag_code, i_clk, i_rst_n, o_valid, o_range_flag != 2'd3, "undefined range flag")
    `ASSERT_IMPL(a_low_clamp, i_clk, i_rst_n, o_valid && o_range_flag == FLAG_LOW, o_index_real == pwlci_point('0).re && o_index_imag == pwlci_point('0).im, "low clamp not first entry")
    `ASSERT_IMPL(a_queue_bound, i_clk, i_rst_n, 1'b1, q_stat.level <= Q_LW'(Q_DEPTH), "queue overfilled")

endmodule
